FILE: hw/rtl/assert_macros.svh
// assertion macros shared by the rx, dump and output stage files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked out of reset
`define TLPC_ASSERT_IMP(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("same-cycle check failed");

// next-cycle implication, checked out of reset
`define TLPC_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

`endif

FILE: hw/rtl/tlpc_pkg.sv
// shared constants, types and helpers of the thermal line packet capture block
package tlpc_pkg;

	// frame and packet geometry
	localparam int LINE_PIXELS  = 80;
	localparam int FRAME_LINES  = 60;
	localparam int PACKET_BYTES = 164;

	localparam int STORE_DEPTH = LINE_PIXELS * FRAME_LINES;
	localparam int ADDR_W      = $clog2(STORE_DEPTH);
	localparam int ROW_W       = $clog2(FRAME_LINES);
	localparam int COL_W       = $clog2(LINE_PIXELS);
	localparam int POS_W       = $clog2(PACKET_BYTES);

	// byte positions inside a packet
	localparam logic [POS_W-1:0] POS_ID     = POS_W'(0);
	localparam logic [POS_W-1:0] POS_LINE   = POS_W'(1);
	localparam logic [POS_W-1:0] POS_CRC_HI = POS_W'(2);
	localparam logic [POS_W-1:0] POS_CRC_LO = POS_W'(3);
	localparam logic [POS_W-1:0] POS_PIXELS = POS_W'(4);
	localparam logic [POS_W-1:0] POS_LAST   = POS_W'(PACKET_BYTES - 1);

	localparam logic [3:0] DISCARD_NIBBLE = 4'hF;

	// dump header, sent first to last
	localparam logic [7:0] HDR_BYTE0 = 8'hDE;
	localparam logic [7:0] HDR_BYTE1 = 8'hAD;
	localparam logic [7:0] HDR_BYTE2 = 8'hBE;
	localparam logic [7:0] HDR_BYTE3 = 8'hEF;

	// configuration registers
	localparam logic REG_OUTPUT_EVERY = 1'b0;
	localparam logic REG_LOST_LIMIT   = 1'b1;
	localparam logic [7:0] OUTPUT_EVERY_RST = 8'd18;
	localparam logic [9:0] LOST_LIMIT_RST   = 10'd100;

	// result kind codes on the port
	localparam logic KIND_SERIAL = 1'b0;
	localparam logic KIND_STATUS = 1'b1;

	// result descriptor handed to the output stage
	typedef enum logic [1:0] {
		RES_STATUS,
		RES_HEADER,
		RES_PIXEL
	} res_kind_t;

	typedef struct packed {
		logic      valid;
		res_kind_t rkind;
		logic [7:0] hdr_byte;
		logic      resync;
		logic      started;
	} res_desc_t;

	// frame store write and read requests
	typedef struct packed {
		logic              en;
		logic [ROW_W-1:0]  row;
		logic [ADDR_W-1:0] addr;
		logic [15:0]       data;
	} wr_req_t;

	typedef struct packed {
		logic              en;
		logic [ROW_W-1:0]  row;
		logic [ADDR_W-1:0] addr;
	} rd_req_t;

	// first store address of a frame line
	function automatic logic [ADDR_W-1:0] line_base(input logic [ROW_W-1:0] row);
		return ADDR_W'(row) * ADDR_W'(LINE_PIXELS);
	endfunction

endpackage

FILE: hw/rtl/tlpc_frame_ram.sv
// frame store: single write port, registered read port, per-row written flags
module tlpc_frame_ram (
	input  logic               clk,
	input  logic               arst_n,
	input  tlpc_pkg::wr_req_t  wr,
	input  tlpc_pkg::rd_req_t  rd,
	output logic [15:0]        rd_data
);

	logic [15:0] store_mem [tlpc_pkg::STORE_DEPTH];
	logic [15:0] raw_q;
	logic        rd_vld_q;
	logic [tlpc_pkg::FRAME_LINES-1:0] row_vld_q;

	// memory array
	always_ff @(posedge clk) begin
		if (wr.en) begin
			store_mem[wr.addr] <= wr.data;
		end
		if (rd.en) begin
			raw_q <= store_mem[rd.addr];
		end
	end

	// rows never written since reset read as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_vld_q <= '0;
			rd_vld_q  <= 1'b0;
		end else begin
			if (wr.en) begin
				row_vld_q[wr.row] <= 1'b1;
			end
			if (rd.en) begin
				rd_vld_q <= row_vld_q[rd.row];
			end
		end
	end

	assign rd_data = rd_vld_q ? raw_q : 16'd0;

endmodule

FILE: hw/rtl/tlpc_rx_ctrl.sv
// packet byte parser, line store writes, frame and loss tracking
`include "assert_macros.svh"

module tlpc_rx_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 byte_acc,
	input  logic [7:0]           rx_byte,
	input  logic                 dump_idle,
	input  logic [7:0]           output_every,
	input  logic [9:0]           lost_limit,
	output tlpc_pkg::wr_req_t    wr,
	output tlpc_pkg::res_desc_t  desc,
	output logic                 dump_start
);

	logic [tlpc_pkg::POS_W-1:0] pos_q;
	logic        usable_q;
	logic [7:0]  line_q;
	logic        store_en_q;
	logic [7:0]  pend_hi_q;
	logic [15:0] prev_crc_q;
	logic        new_frame_q;
	logic [10:0] loss_q;
	logic [7:0]  modulo_q;

	logic                         eop;
	logic [tlpc_pkg::POS_W-1:0]   off;
	logic [tlpc_pkg::POS_W-2:0]   px;
	logic                         wr_en;
	logic [15:0]                  word;
	logic                         crc_hit;
	logic                         crc_new;
	logic [10:0]                  loss_base;
	logic [10:0]                  loss_inc;
	logic                         lost_line;
	logic                         resync;
	logic                         line_done;
	logic [7:0]                   mod_inc;
	logic                         start;

	// position decode and pixel write
	assign eop   = (pos_q == tlpc_pkg::POS_LAST);
	assign off   = pos_q - tlpc_pkg::POS_PIXELS;
	assign px    = off[tlpc_pkg::POS_W-1:1];
	assign word  = {pend_hi_q, rx_byte};
	assign wr_en = byte_acc && (pos_q >= tlpc_pkg::POS_PIXELS) && off[0] && store_en_q
		&& (px < (tlpc_pkg::POS_W-1)'(tlpc_pkg::LINE_PIXELS))
		&& (line_q < 8'(tlpc_pkg::FRAME_LINES));

	assign wr.en   = wr_en;
	assign wr.row  = line_q[tlpc_pkg::ROW_W-1:0];
	assign wr.addr = tlpc_pkg::line_base(line_q[tlpc_pkg::ROW_W-1:0])
		+ tlpc_pkg::ADDR_W'(px);
	assign wr.data = word;

	// new frame detection on line zero
	assign crc_hit = (pos_q == tlpc_pkg::POS_CRC_LO) && usable_q && (line_q == 8'd0);
	assign crc_new = crc_hit && (word != prev_crc_q);

	// end of packet loss accounting
	assign lost_line = usable_q && (line_q >= 8'(tlpc_pkg::FRAME_LINES));
	assign loss_base = crc_new ? 11'd0 : loss_q;
	assign loss_inc  = loss_base + 11'd1 + {10'd0, lost_line};
	assign resync    = loss_inc > {1'b0, lost_limit};

	// frame completion and dump start
	assign line_done = usable_q && (line_q == 8'(tlpc_pkg::FRAME_LINES - 1));
	assign mod_inc   = modulo_q + 8'd1;
	assign start     = byte_acc && eop && line_done && new_frame_q
		&& (mod_inc >= output_every);
	assign dump_start = start;

	// status result at the last byte of a packet
	assign desc.valid    = byte_acc && eop;
	assign desc.rkind    = tlpc_pkg::RES_STATUS;
	assign desc.hdr_byte = 8'd0;
	assign desc.resync   = resync;
	assign desc.started  = start;

	// parser state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q       <= '0;
			usable_q    <= 1'b0;
			line_q      <= 8'd0;
			store_en_q  <= 1'b0;
			pend_hi_q   <= 8'd0;
			prev_crc_q  <= 16'd0;
			new_frame_q <= 1'b0;
			loss_q      <= 11'd0;
			modulo_q    <= 8'd0;
		end else if (byte_acc) begin
			if (pos_q == tlpc_pkg::POS_ID) begin
				usable_q <= (rx_byte[3:0] != tlpc_pkg::DISCARD_NIBBLE);
			end else if (pos_q == tlpc_pkg::POS_LINE) begin
				line_q     <= rx_byte;
				store_en_q <= usable_q && (rx_byte < 8'(tlpc_pkg::FRAME_LINES)) && dump_idle;
			end else if (pos_q == tlpc_pkg::POS_CRC_HI) begin
				pend_hi_q <= rx_byte;
			end else if (pos_q == tlpc_pkg::POS_CRC_LO) begin
				if (crc_hit) begin
					prev_crc_q <= word;
				end
				if (crc_new) begin
					loss_q      <= 11'd0;
					new_frame_q <= 1'b1;
				end
			end else if (!off[0]) begin
				pend_hi_q <= rx_byte;
			end

			if (eop) begin
				pos_q  <= '0;
				loss_q <= resync ? 11'd0 : loss_inc;
				if (line_done) begin
					new_frame_q <= 1'b0;
					if (new_frame_q) begin
						modulo_q <= start ? 8'd0 : mod_inc;
					end
				end
			end else begin
				pos_q <= pos_q + 1'b1;
			end
		end
	end

	`TLPC_ASSERT_IMP(a_wr_in_frame, clk, arst_n, wr_en, (line_q < 8'(tlpc_pkg::FRAME_LINES)) && (pos_q >= tlpc_pkg::POS_PIXELS))

endmodule

FILE: hw/rtl/tlpc_dump_ctrl.sv
// image dump sequencer: header bytes then frame store reads, one step per tick
`include "assert_macros.svh"

module tlpc_dump_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 tick_acc,
	input  logic                 start,
	output logic                 idle,
	output tlpc_pkg::rd_req_t    rd,
	output tlpc_pkg::res_desc_t  desc
);

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_HDR0,
		PH_HDR1,
		PH_HDR2,
		PH_HDR3,
		PH_PIXELS
	} dump_phase_t;

	dump_phase_t                 phase_q;
	logic [tlpc_pkg::ROW_W-1:0]  row_q;
	logic [tlpc_pkg::COL_W-1:0]  col_q;
	logic [7:0]                  hdr;
	logic                        in_hdr;

	// header byte for the current phase
	always_comb begin
		in_hdr = 1'b1;
		hdr    = 8'd0;
		unique case (phase_q)
			PH_HDR0: hdr = tlpc_pkg::HDR_BYTE0;
			PH_HDR1: hdr = tlpc_pkg::HDR_BYTE1;
			PH_HDR2: hdr = tlpc_pkg::HDR_BYTE2;
			PH_HDR3: hdr = tlpc_pkg::HDR_BYTE3;
			default: in_hdr = 1'b0;
		endcase
	end

	assign idle = (phase_q == PH_IDLE);

	// frame store read for a pixel tick
	assign rd.en   = tick_acc && (phase_q == PH_PIXELS);
	assign rd.row  = row_q;
	assign rd.addr = tlpc_pkg::line_base(row_q) + tlpc_pkg::ADDR_W'(col_q);

	// result descriptor for this tick
	assign desc.valid    = tick_acc && (in_hdr || (phase_q == PH_PIXELS));
	assign desc.rkind    = in_hdr ? tlpc_pkg::RES_HEADER : tlpc_pkg::RES_PIXEL;
	assign desc.hdr_byte = hdr;
	assign desc.resync   = 1'b0;
	assign desc.started  = 1'b0;

	// sequencer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			row_q   <= '0;
			col_q   <= '0;
		end else if (start) begin
			phase_q <= PH_HDR0;
			row_q   <= '0;
			col_q   <= '0;
		end else if (tick_acc) begin
			unique case (phase_q)
				PH_HDR0: phase_q <= PH_HDR1;
				PH_HDR1: phase_q <= PH_HDR2;
				PH_HDR2: phase_q <= PH_HDR3;
				PH_HDR3: begin
					phase_q <= PH_PIXELS;
					row_q   <= '0;
					col_q   <= '0;
				end
				PH_PIXELS: begin
					if (col_q == tlpc_pkg::COL_W'(tlpc_pkg::LINE_PIXELS - 1)) begin
						col_q <= '0;
						row_q <= row_q + 1'b1;
						if (row_q == tlpc_pkg::ROW_W'(tlpc_pkg::FRAME_LINES - 1)) begin
							phase_q <= PH_IDLE;
						end
					end else begin
						col_q <= col_q + 1'b1;
					end
				end
				default: phase_q <= PH_IDLE;
			endcase
		end
	end

	`TLPC_ASSERT_NEXT(a_start_at_header, clk, arst_n, start, (phase_q == PH_HDR0) && (row_q == '0) && (col_q == '0))

endmodule

FILE: hw/rtl/tlpc_out_stage.sv
// staging slot and output register; a pixel leaves as high then low byte
`include "assert_macros.svh"

module tlpc_out_stage (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 load,
	input  tlpc_pkg::res_desc_t  desc,
	input  logic [15:0]          pix_data,
	output logic                 in_ready,
	output logic                 res_valid,
	input  logic                 res_ready,
	output logic                 kind,
	output logic [7:0]           out_byte,
	output logic                 last_of_run,
	output logic                 resync_request,
	output logic                 dump_started
);

	logic                 valid_s1;
	tlpc_pkg::res_desc_t  desc_s1;
	logic                 lo_pend_s1;

	logic       out_valid_q;
	logic       kind_q;
	logic [7:0] byte_q;
	logic       last_q;
	logic       resync_q;
	logic       started_q;

	logic       out_free;
	logic       s1_move;
	logic       s1_done;
	logic       nx_kind;
	logic [7:0] nx_byte;
	logic       nx_last;
	logic       nx_resync;
	logic       nx_started;

	// slot flow control
	assign out_free = !out_valid_q || res_ready;
	assign s1_move  = valid_s1 && out_free;
	assign s1_done  = s1_move && ((desc_s1.rkind != tlpc_pkg::RES_PIXEL) || lo_pend_s1);
	assign in_ready = !valid_s1 || s1_done;

	// result fields from the staged descriptor
	always_comb begin
		nx_kind    = tlpc_pkg::KIND_SERIAL;
		nx_byte    = 8'd0;
		nx_last    = 1'b1;
		nx_resync  = 1'b0;
		nx_started = 1'b0;
		unique case (desc_s1.rkind)
			tlpc_pkg::RES_STATUS: begin
				nx_kind    = tlpc_pkg::KIND_STATUS;
				nx_resync  = desc_s1.resync;
				nx_started = desc_s1.started;
			end
			tlpc_pkg::RES_HEADER: begin
				nx_byte = desc_s1.hdr_byte;
			end
			tlpc_pkg::RES_PIXEL: begin
				nx_byte = lo_pend_s1 ? pix_data[7:0] : pix_data[15:8];
				nx_last = lo_pend_s1;
			end
			default: begin
				nx_kind = tlpc_pkg::KIND_STATUS;
			end
		endcase
	end

	// staging slot
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1   <= 1'b0;
			lo_pend_s1 <= 1'b0;
		end else if (load && desc.valid) begin
			valid_s1   <= 1'b1;
			lo_pend_s1 <= 1'b0;
		end else if (s1_done) begin
			valid_s1   <= 1'b0;
			lo_pend_s1 <= 1'b0;
		end else if (s1_move) begin
			lo_pend_s1 <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (load && desc.valid) begin
			desc_s1 <= desc;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_move) begin
			out_valid_q <= 1'b1;
		end else if (res_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_move) begin
			kind_q    <= nx_kind;
			byte_q    <= nx_byte;
			last_q    <= nx_last;
			resync_q  <= nx_resync;
			started_q <= nx_started;
		end
	end

	assign res_valid      = out_valid_q;
	assign kind           = kind_q;
	assign out_byte       = byte_q;
	assign last_of_run    = last_q;
	assign resync_request = resync_q;
	assign dump_started   = started_q;

	`TLPC_ASSERT_IMP(a_low_only_pixel, clk, arst_n, valid_s1 && lo_pend_s1, desc_s1.rkind == tlpc_pkg::RES_PIXEL)
	`TLPC_ASSERT_NEXT(a_high_then_low, clk, arst_n, s1_move && (desc_s1.rkind == tlpc_pkg::RES_PIXEL) && !lo_pend_s1, valid_s1 && lo_pend_s1 && out_valid_q && !last_q)

endmodule

FILE: hw/rtl/thermal_line_packet_capture.sv
// thermal line packet capture: top level with configuration registers
//
//   channel   signals                                          direction
//   item      item_valid/item_ready, func, rx_byte             in
//   result    res_valid/res_ready, kind, out_byte, last_of_run,
//             resync_request, dump_started                     out
//   config    psel/penable/pwrite/paddr/pwdata/prdata/pready   apb
//
// one item is taken per cycle while item_ready is high; a result moves through
// the staging slot, then the output register. a pixel tick yields two result
// bytes from one frame store read and holds the slot until both move on.
// item_ready drops only while the staging slot holds a result not yet moved on;
// res_ready low holds the output register and backs up into that slot.
// reset clears all control state; the frame store takes no clearing pass, rows
// not written since reset read as zero through per-row written flags.
module thermal_line_packet_capture (
	input  logic        clk,
	input  logic        arst_n,

	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,

	input  logic        item_valid,
	output logic        item_ready,
	input  logic        func,
	input  logic [7:0]  rx_byte,

	output logic        res_valid,
	input  logic        res_ready,
	output logic        kind,
	output logic [7:0]  out_byte,
	output logic        last_of_run,
	output logic        resync_request,
	output logic        dump_started
);

	logic [7:0] output_every_q;
	logic [9:0] lost_limit_q;

	logic       cfg_wr;
	logic       reg_idx;
	logic       accept;
	logic       byte_acc;
	logic       tick_acc;
	logic       dump_idle;
	logic       dump_start;
	logic [15:0] pix_data;

	tlpc_pkg::wr_req_t   wr;
	tlpc_pkg::rd_req_t   rd;
	tlpc_pkg::res_desc_t rx_desc;
	tlpc_pkg::res_desc_t dump_desc;
	tlpc_pkg::res_desc_t desc;

	// configuration port
	assign pready  = 1'b1;
	assign reg_idx = paddr[2];
	assign cfg_wr  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			output_every_q <= tlpc_pkg::OUTPUT_EVERY_RST;
			lost_limit_q   <= tlpc_pkg::LOST_LIMIT_RST;
		end else if (cfg_wr) begin
			unique case (reg_idx)
				tlpc_pkg::REG_OUTPUT_EVERY: output_every_q <= pwdata[7:0];
				tlpc_pkg::REG_LOST_LIMIT:   lost_limit_q   <= pwdata[9:0];
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			tlpc_pkg::REG_OUTPUT_EVERY: prdata = {24'd0, output_every_q};
			tlpc_pkg::REG_LOST_LIMIT:   prdata = {22'd0, lost_limit_q};
		endcase
	end

	// item transaction split into packet bytes and transmit ticks
	assign accept   = item_valid && item_ready;
	assign byte_acc = accept && !func;
	assign tick_acc = accept && func;
	assign desc     = func ? dump_desc : rx_desc;

	tlpc_rx_ctrl u_rx_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.byte_acc     (byte_acc),
		.rx_byte      (rx_byte),
		.dump_idle    (dump_idle),
		.output_every (output_every_q),
		.lost_limit   (lost_limit_q),
		.wr           (wr),
		.desc         (rx_desc),
		.dump_start   (dump_start)
	);

	tlpc_dump_ctrl u_dump_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.tick_acc (tick_acc),
		.start    (dump_start),
		.idle     (dump_idle),
		.rd       (rd),
		.desc     (dump_desc)
	);

	tlpc_frame_ram u_frame_ram (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (wr),
		.rd      (rd),
		.rd_data (pix_data)
	);

	tlpc_out_stage u_out_stage (
		.clk            (clk),
		.arst_n         (arst_n),
		.load           (accept),
		.desc           (desc),
		.pix_data       (pix_data),
		.in_ready       (item_ready),
		.res_valid      (res_valid),
		.res_ready      (res_ready),
		.kind           (kind),
		.out_byte       (out_byte),
		.last_of_run    (last_of_run),
		.resync_request (resync_request),
		.dump_started   (dump_started)
	);

endmodule
